// ----- rtl/bpfa_pkg.sv -----
// ============================================================================
// bpfa_pkg
// Shared constants, types and control structs of the page frame allocator.
// ============================================================================
package bpfa_pkg;

	localparam int NUM_FRAMES     = 32768;
	localparam int FRAME_BYTES    = 4096;
	localparam int FRAME_SHIFT    = $clog2(FRAME_BYTES);
	localparam int FRAME_W        = $clog2(NUM_FRAMES);

	localparam int IN_ADDR_W      = 32;
	localparam int ADDR_W         = 27;
	localparam int CNT_W          = 16;
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 1;

	localparam int WORD_BITS      = 64;
	localparam int BIT_W          = $clog2(WORD_BITS);
	localparam int MAP_BYTES      = NUM_FRAMES / 8;
	localparam int MAP_WORDS      = NUM_FRAMES / WORD_BITS;
	localparam int WORD_AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int MAP_BYTES_W    = $clog2(MAP_BYTES) + 1;
	localparam int WIN_W          = (CFG_W - 2 > MAP_BYTES_W) ? CFG_W - 2 : MAP_BYTES_W;
	localparam int PTR_W          = WIN_W - 2;

	localparam logic [CNT_W-1:0] CNT_MAX         = {CNT_W{1'b1}};
	localparam logic [CFG_W-1:0] MAX_FRAME_RESET = CFG_W'(32768);

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 1'b1;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_OOM          = 2'd1,
		ST_ALREADY_FREE = 2'd2,
		ST_OUTSIDE      = 2'd3
	} status_t;

	typedef struct packed {
		logic clear_en;
		logic accept_alloc;
		logic accept_free;
		logic scan_en;
		logic free_rd;
		logic free_chk;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic win_empty;
		logic free_outside;
		logic scan_hit;
		logic scan_end;
	} sts_t;

endpackage

// ----- rtl/bpfa_ifs.sv -----
// ============================================================================
// bpfa request and response channels
// Valid/ready channels carrying one request beat and one response beat.
// ============================================================================
interface bpfa_req_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [bpfa_pkg::IN_ADDR_W-1:0] frame_address;

	modport source (output valid, output kind, output frame_address, input ready);
	modport sink   (input valid, input kind, input frame_address, output ready);
endinterface

interface bpfa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bpfa_pkg::ADDR_W-1:0] result_address;
	bpfa_pkg::status_t           status;
	logic [bpfa_pkg::CNT_W-1:0]  allocated_count;

	modport source (output valid, output result_address, output status,
		output allocated_count, input ready);
	modport sink   (input valid, input result_address, input status,
		input allocated_count, output ready);
endinterface

// ----- rtl/bpfa_ctrl.sv -----
// ============================================================================
// bpfa_ctrl
// Sequencer: clearing pass, request accept, map scan, free check, response.
// ============================================================================
module bpfa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_kind,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  bpfa_pkg::sts_t sts,
	output bpfa_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_FRD   = 6'b001000,
		S_FCHK  = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_kind == bpfa_pkg::KIND_ALLOC) begin
						cmd.accept_alloc = 1'b1;
						state_d = sts.win_empty ? S_FIN : S_SCAN;
					end else begin
						cmd.accept_free = 1'b1;
						state_d = sts.free_outside ? S_FIN : S_FRD;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_hit || sts.scan_end) begin
					state_d = S_FIN;
				end
			end
			S_FRD: begin
				cmd.free_rd = 1'b1;
				state_d = S_FCHK;
			end
			S_FCHK: begin
				cmd.free_chk = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ----- rtl/bpfa_dpath.sv -----
// ============================================================================
// bpfa_dpath
// Map memory, window registers, scan pointer, frame search and used count.
// ============================================================================
module bpfa_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpfa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bpfa_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [bpfa_pkg::IN_ADDR_W-1:0] frame_address,
	input  bpfa_pkg::cmd_t                 cmd,
	output bpfa_pkg::sts_t                 sts,
	output logic [bpfa_pkg::ADDR_W-1:0]    result_address,
	output bpfa_pkg::status_t              status,
	output logic [bpfa_pkg::CNT_W-1:0]     allocated_count
);

	logic [bpfa_pkg::WORD_BITS-1:0] map_mem [bpfa_pkg::MAP_WORDS];

	logic [bpfa_pkg::CFG_W-1:0]     min_frame_q;
	logic [bpfa_pkg::CFG_W-1:0]     max_frame_q;
	logic [bpfa_pkg::WIN_W-1:0]     start_b;
	logic [bpfa_pkg::WIN_W-1:0]     max_b;
	logic [bpfa_pkg::WIN_W-1:0]     end_b;
	logic [bpfa_pkg::WIN_W-1:0]     start_b_q;
	logic [bpfa_pkg::WIN_W-1:0]     end_b_q;
	logic [bpfa_pkg::PTR_W-1:0]     rd_ptr_q;
	logic [bpfa_pkg::PTR_W-1:0]     last_q;
	logic                           rd_more;
	logic                           scan_rd;
	logic                           rd_en;
	logic [bpfa_pkg::WORD_AW-1:0]   rd_addr;
	logic [bpfa_pkg::WORD_BITS-1:0] rdata_s1;
	logic                           chk_vld_s1;
	logic [bpfa_pkg::WORD_AW-1:0]   chk_ptr_s1;
	logic [bpfa_pkg::WORD_AW-1:0]   clr_ptr_q;
	logic [bpfa_pkg::IN_ADDR_W-1:0] idx_full;
	logic [bpfa_pkg::FRAME_W-1:0]   fidx_q;
	logic [bpfa_pkg::WORD_AW-1:0]   fword;
	logic                           frame_used;

	logic [7:0]                     byte_full;
	logic [2:0]                     byte_sel;
	logic [2:0]                     bit_sel;
	logic [7:0]                     sel_byte;
	logic                           any_zero;
	logic [bpfa_pkg::WIN_W-1:0]     gbyte;
	logic [bpfa_pkg::BIT_W-1:0]     hit_pos;
	logic [bpfa_pkg::FRAME_W-1:0]   hit_frame;
	logic [bpfa_pkg::FRAME_W+bpfa_pkg::FRAME_SHIFT-1:0] hit_byte_addr;

	logic                           wr_en;
	logic [bpfa_pkg::WORD_AW-1:0]   wr_addr;
	logic [bpfa_pkg::WORD_BITS-1:0] wr_data;
	logic                           do_hit;
	logic                           do_release;

	logic [bpfa_pkg::CNT_W-1:0]     count_q;
	logic [bpfa_pkg::ADDR_W-1:0]    pend_addr_q;
	bpfa_pkg::status_t              pend_status_q;
	logic [bpfa_pkg::ADDR_W-1:0]    rsp_addr_q;
	bpfa_pkg::status_t              rsp_status_q;
	logic [bpfa_pkg::CNT_W-1:0]     rsp_count_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_frame_q <= '0;
			max_frame_q <= bpfa_pkg::MAX_FRAME_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				bpfa_pkg::CFG_MIN_FRAME: min_frame_q <= cfg_wdata;
				bpfa_pkg::CFG_MAX_FRAME: max_frame_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// scan window in map bytes
	always_comb begin
		start_b = bpfa_pkg::WIN_W'(min_frame_q >> 3)
			+ bpfa_pkg::WIN_W'(min_frame_q[2:0] != 3'd0);
		max_b   = bpfa_pkg::WIN_W'(max_frame_q >> 3);
		end_b   = (max_b > bpfa_pkg::WIN_W'(bpfa_pkg::MAP_BYTES))
			? bpfa_pkg::WIN_W'(bpfa_pkg::MAP_BYTES) : max_b;
	end

	assign idx_full = frame_address >> bpfa_pkg::FRAME_SHIFT;
	assign rd_more  = (rd_ptr_q <= last_q);
	assign scan_rd  = cmd.scan_en && rd_more;
	assign rd_en    = scan_rd || cmd.free_rd;
	assign fword    = fidx_q[bpfa_pkg::BIT_W +: bpfa_pkg::WORD_AW];
	assign rd_addr  = cmd.free_rd ? fword : rd_ptr_q[bpfa_pkg::WORD_AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.accept_alloc) begin
			start_b_q <= start_b;
			end_b_q   <= end_b;
			last_q    <= bpfa_pkg::PTR_W'((end_b - bpfa_pkg::WIN_W'(1)) >> 3);
		end
		if (cmd.accept_alloc) begin
			rd_ptr_q <= bpfa_pkg::PTR_W'(start_b >> 3);
		end else if (scan_rd) begin
			rd_ptr_q <= rd_ptr_q + bpfa_pkg::PTR_W'(1);
		end
		if (cmd.accept_free) begin
			fidx_q <= bpfa_pkg::FRAME_W'(idx_full);
		end
		chk_ptr_s1 <= rd_ptr_q[bpfa_pkg::WORD_AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_vld_s1 <= 1'b0;
			clr_ptr_q  <= '0;
		end else begin
			chk_vld_s1 <= scan_rd;
			if (cmd.clear_en) begin
				clr_ptr_q <= clr_ptr_q + bpfa_pkg::WORD_AW'(1);
			end
		end
	end

	// map memory
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= map_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
	end

	// first non-full in-window byte, then its lowest clear bit
	always_comb begin
		byte_full = '0;
		byte_sel  = '0;
		bit_sel   = '0;
		gbyte     = '0;
		for (int j = 0; j < 8; j++) begin
			gbyte = bpfa_pkg::WIN_W'({chk_ptr_s1, 3'(j)});
			byte_full[j] = (&rdata_s1[8*j +: 8]) || (gbyte < start_b_q)
				|| (gbyte >= end_b_q);
		end
		any_zero = ~&byte_full;
		for (int j = 7; j >= 0; j--) begin
			if (!byte_full[j]) begin
				byte_sel = 3'(j);
			end
		end
		sel_byte = rdata_s1[byte_sel*8 +: 8];
		for (int i = 7; i >= 0; i--) begin
			if (!sel_byte[i]) begin
				bit_sel = 3'(i);
			end
		end
	end

	assign hit_pos       = {byte_sel, bit_sel};
	assign hit_frame     = bpfa_pkg::FRAME_W'({chk_ptr_s1, hit_pos});
	assign hit_byte_addr = {hit_frame, {bpfa_pkg::FRAME_SHIFT{1'b0}}};
	assign frame_used    = rdata_s1[fidx_q[bpfa_pkg::BIT_W-1:0]];

	assign do_hit     = cmd.scan_en && chk_vld_s1 && any_zero;
	assign do_release = cmd.free_chk && frame_used;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_ptr_q;
		wr_data = '0;
		if (cmd.clear_en) begin
			wr_en = 1'b1;
		end else if (do_hit) begin
			wr_en   = 1'b1;
			wr_addr = chk_ptr_s1;
			wr_data = rdata_s1 | (bpfa_pkg::WORD_BITS'(1) << hit_pos);
		end else if (do_release) begin
			wr_en   = 1'b1;
			wr_addr = fword;
			wr_data = rdata_s1 & ~(bpfa_pkg::WORD_BITS'(1) << fidx_q[bpfa_pkg::BIT_W-1:0]);
		end
	end

	// used count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_hit && count_q != bpfa_pkg::CNT_MAX) begin
			count_q <= count_q + bpfa_pkg::CNT_W'(1);
		end else if (do_release && count_q != '0) begin
			count_q <= count_q - bpfa_pkg::CNT_W'(1);
		end
	end

	// pending result and response register
	always_ff @(posedge clk) begin
		if (cmd.accept_alloc) begin
			pend_addr_q   <= '0;
			pend_status_q <= bpfa_pkg::ST_OOM;
		end else if (cmd.accept_free) begin
			pend_addr_q   <= '0;
			pend_status_q <= bpfa_pkg::ST_OUTSIDE;
		end else if (do_hit) begin
			pend_addr_q   <= bpfa_pkg::ADDR_W'(hit_byte_addr);
			pend_status_q <= bpfa_pkg::ST_OK;
		end else if (cmd.free_chk) begin
			pend_status_q <= frame_used ? bpfa_pkg::ST_OK : bpfa_pkg::ST_ALREADY_FREE;
		end
		if (cmd.out_load) begin
			rsp_addr_q   <= pend_addr_q;
			rsp_status_q <= pend_status_q;
			rsp_count_q  <= count_q;
		end
	end

	always_comb begin
		sts              = '0;
		sts.clear_done   = (clr_ptr_q == bpfa_pkg::WORD_AW'(bpfa_pkg::MAP_WORDS - 1));
		sts.win_empty    = (start_b >= end_b);
		sts.free_outside = (idx_full >= bpfa_pkg::IN_ADDR_W'(bpfa_pkg::NUM_FRAMES));
		sts.scan_hit     = chk_vld_s1 && any_zero;
		sts.scan_end     = !rd_more;
	end

	assign result_address  = rsp_addr_q;
	assign status          = rsp_status_q;
	assign allocated_count = rsp_count_q;

endmodule

// ----- rtl/bitmap_page_frame_allocator.sv -----
// ============================================================================
// bitmap_page_frame_allocator
// First-fit page frame allocator over a used/free bitmap of page frames.
// ============================================================================
//  channel  dir  beat contents                                 handshake
//  req      in   kind, frame_address                           valid/ready
//  rsp      out  result_address, status, allocated_count       valid/ready
//  cfg      in   cfg_idx, cfg_wdata (min_frame, max_frame)     cfg_we
//
// Allocate: a scan over N 64-bit map words (1 to 512) follows the accept;
// the scan reads one map word per cycle from the single read port.
// Free: accept, map read, check and write back, response.
// An empty-window allocate and an outside-the-map free go straight to response.
// After reset a clearing pass zeroes all 512 map words, one word a cycle;
// req.ready stays low during it. A response beat waits in its register; the
// next request is taken meanwhile and finishes once that register is free.
// ============================================================================
module bitmap_page_frame_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	bpfa_req_if.sink                       req,
	bpfa_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [bpfa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bpfa_pkg::CFG_W-1:0]     cfg_wdata
);

	bpfa_pkg::cmd_t cmd;
	bpfa_pkg::sts_t sts;

	bpfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.kind),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bpfa_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.frame_address   (req.frame_address),
		.cmd             (cmd),
		.sts             (sts),
		.result_address  (rsp.result_address),
		.status          (rsp.status),
		.allocated_count (rsp.allocated_count)
	);

endmodule
